/* rtl/button_debounce_auto_repeat_top_assert.svh */
// Assertion macros for the button debounce / auto repeat block.
// Used by button_debounce_auto_repeat_top; needs clk and rst in scope.
`ifndef BUTTON_DEBOUNCE_AUTO_REPEAT_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTO_REPEAT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BDAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdar assertion failed");

// Next-cycle implication, checked out of reset.
`define BDAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdar assertion failed");

`endif

/* rtl/bdar_pkg.sv */
// Shared types and constants for the button debounce / auto repeat block.
// No dependencies.
package bdar_pkg;

  localparam int CFG_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int EVENT_W      = 2;
  localparam int TIMER_BITS_D = 24;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = CFG_W'(50000);
  localparam logic [CFG_W-1:0] HOLD_INITIAL_RST = CFG_W'(500000);
  localparam logic [CFG_W-1:0] HOLD_REPEAT_RST  = CFG_W'(200000);
  localparam logic             HOLD_ENABLE_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_HOLD_INITIAL = 2'd1,
    REG_HOLD_REPEAT  = 2'd2,
    REG_HOLD_ENABLE  = 2'd3
  } reg_index_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 2'd0,
    EV_PRESS  = 2'd1,
    EV_REPEAT = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] hold_initial_ticks;
    logic [CFG_W-1:0] hold_repeat_ticks;
    logic             hold_enable;
  } cfg_t;

  typedef struct packed {
    logic stage_valid;
    logic in_hold;
  } core_status_t;

endpackage

/* rtl/bdar_ifs.sv */
// Valid/ready channel interfaces: timer tick beats in, event beats out.
// Depends on bdar_pkg for payload widths.
interface bdar_tick_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface bdar_event_if;
  logic                         valid;
  logic                         ready;
  logic [bdar_pkg::EVENT_W-1:0] event_kind;
  logic                         held;

  modport source (output valid, output event_kind, output held, input ready);
  modport sink (input valid, input event_kind, input held, output ready);
endinterface

/* rtl/bdar_cfg.sv */
// Configuration register file for the debounce / auto repeat block.
// Depends on bdar_pkg.
module bdar_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bdar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdar_pkg::CFG_W-1:0]     cfg_data,
  output bdar_pkg::cfg_t                 cfg
);
  import bdar_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks     <= DEBOUNCE_RST;
      regs.hold_initial_ticks <= HOLD_INITIAL_RST;
      regs.hold_repeat_ticks  <= HOLD_REPEAT_RST;
      regs.hold_enable        <= HOLD_ENABLE_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE:     regs.debounce_ticks     <= cfg_data;
        REG_HOLD_INITIAL: regs.hold_initial_ticks <= cfg_data;
        REG_HOLD_REPEAT:  regs.hold_repeat_ticks  <= cfg_data;
        REG_HOLD_ENABLE:  regs.hold_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;
endmodule

/* rtl/bdar_core.sv */
// Tick input register, debounce / hold state and registered event output.
// Depends on bdar_pkg and the channel interfaces in bdar_ifs.sv.
module bdar_core #(
  parameter int TIMER_BITS = bdar_pkg::TIMER_BITS_D
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bdar_pkg::cfg_t         cfg,
  bdar_tick_if.sink              tick,
  bdar_event_if.source           evt,
  output bdar_pkg::core_status_t status
);
  import bdar_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + TIMER_BITS'(1);
  endfunction

  // input stage
  logic stage_valid;
  logic stage_level;
  // state
  logic                  previous_level, previous_level_next;
  logic [TIMER_BITS-1:0] since_press, since_press_next;
  logic                  in_hold, in_hold_next;
  logic [TIMER_BITS-1:0] hold_elapsed, hold_elapsed_next;
  logic [TIMER_BITS-1:0] since_repeat, since_repeat_next;
  // output stage
  logic        out_valid;
  event_kind_t out_kind;
  logic        out_held;

  event_kind_t           kind;
  logic [TIMER_BITS-1:0] press_inc;
  logic [TIMER_BITS-1:0] repeat_inc;
  logic                  advance;

  assign advance    = stage_valid && (!out_valid || evt.ready);
  assign tick.ready = !stage_valid || advance;

  always_comb begin
    press_inc           = sat_inc(since_press);
    repeat_inc          = sat_inc(since_repeat);
    kind                = EV_NONE;
    previous_level_next = stage_level;
    since_press_next    = press_inc;
    in_hold_next        = in_hold;
    hold_elapsed_next   = hold_elapsed;
    since_repeat_next   = since_repeat;
    if (in_hold) begin
      since_press_next = '0;
      if (!stage_level) begin
        hold_elapsed_next = sat_inc(hold_elapsed);
        since_repeat_next = repeat_inc;
        if ((CMP_W'(hold_elapsed_next) > CMP_W'(cfg.hold_initial_ticks)) &&
            (CMP_W'(repeat_inc) > CMP_W'(cfg.hold_repeat_ticks))) begin
          kind              = EV_REPEAT;
          since_repeat_next = '0;
        end
      end else begin
        in_hold_next = 1'b0;
      end
    end else if (previous_level && !stage_level) begin
      // falling edge: a press only once the debounce time has passed
      if (CMP_W'(press_inc) > CMP_W'(cfg.debounce_ticks)) begin
        kind             = EV_PRESS;
        since_press_next = '0;
        if (cfg.hold_enable) begin
          in_hold_next      = 1'b1;
          hold_elapsed_next = '0;
          since_repeat_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      out_valid      <= 1'b0;
      previous_level <= 1'b1;
      since_press    <= '0;
      in_hold        <= 1'b0;
      hold_elapsed   <= '0;
      since_repeat   <= '0;
    end else begin
      if (tick.valid && tick.ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        previous_level <= previous_level_next;
        since_press    <= since_press_next;
        in_hold        <= in_hold_next;
        hold_elapsed   <= hold_elapsed_next;
        since_repeat   <= since_repeat_next;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      stage_level <= tick.button_level;
    end
    if (advance) begin
      out_kind <= kind;
      out_held <= !stage_level;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.event_kind = out_kind;
  assign evt.held       = out_held;

  assign status.stage_valid = stage_valid;
  assign status.in_hold     = in_hold;
endmodule

/* rtl/button_debounce_auto_repeat_top.sv */
// Button debounce with auto repeat: one timer tick beat in, one event beat
// out per tick. Each tick beat carries the sampled, active-low button level.
// A falling edge is a press only when more than debounce_ticks ticks have
// passed since the last accepted press or the end of a followed hold; a
// bounced edge is dropped and does not restart that time. With hold_enable
// set at press time, the hold is followed: once held longer than
// hold_initial_ticks, a repeat event comes out each time more than
// hold_repeat_ticks ticks pass. Counters are TIMER_BITS wide and saturate.
// Throughput is one tick per clock unless the event side stalls; an accepted
// tick beat passes the input register, then the event register. The
// debounce/hold state loop is counter increment, compare and select into the
// state registers. Configuration writes go straight into the register file
// and must only be made while no tick is in flight.
// Depends on bdar_pkg, bdar_ifs.sv, bdar_cfg, bdar_core and the assert header.
`include "button_debounce_auto_repeat_top_assert.svh"

module button_debounce_auto_repeat_top #(
  parameter int TIMER_BITS = bdar_pkg::TIMER_BITS_D
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bdar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdar_pkg::CFG_W-1:0]     cfg_data,
  bdar_tick_if.sink                      tick,
  bdar_event_if.source                   evt
);
  import bdar_pkg::*;

  cfg_t         cfg;
  core_status_t status;

  // register file: debounce, hold initial, hold repeat, hold enable
  bdar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // tick register, state update and event register
  bdar_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .evt    (evt),
    .status (status)
  );

  // any event (press or repeat) is only ever raised on a low level
  `BDAR_ASSERT_NOW(a_event_held, evt.valid && (evt.event_kind != EV_NONE), evt.held)
  // an accepted tick beat always lands in the input stage
  `BDAR_ASSERT_NEXT(a_tick_staged, tick.valid && tick.ready, status.stage_valid)
  // full input stage behind a stalled event register blocks new ticks
  `BDAR_ASSERT_NOW(a_backpressure, status.stage_valid && evt.valid && !evt.ready, !tick.ready)
  // a repeat only comes while a hold was being followed
  `BDAR_ASSERT_NEXT(a_repeat_in_hold, status.stage_valid && !status.in_hold && evt.ready,
                    !(evt.valid && (evt.event_kind == EV_REPEAT)))
endmodule

/* tb/testbench.sv */
// Self-checking bench for button_debounce_auto_repeat_top: ticks in, events out.
// Needs bdar_pkg, the bdar_tick_if / bdar_event_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import bdar_pkg::*;

  typedef logic [TIMER_BITS_D-1:0] ticks_t;

  typedef struct packed {
    event_kind_t kind;
    logic        held;
  } event_beat_t;

  localparam ticks_t CFG_MAX     = '1;
  localparam int     QUIET_LIMIT = 4000;  // cycles with no beat and no write

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bdar_tick_if  tick_ch ();
  bdar_event_if event_ch ();

  button_debounce_auto_repeat_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .evt       (event_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Button tracker: own copy of the settings and of the debounce/hold state
  // ---------------------------------------------------------------------
  ticks_t debounce_limit     = DEBOUNCE_RST;
  ticks_t hold_initial_limit = HOLD_INITIAL_RST;
  ticks_t hold_repeat_limit  = HOLD_REPEAT_RST;
  logic   hold_enable_bit    = HOLD_ENABLE_RST;

  logic   last_level   = 1'b1;
  ticks_t since_press  = '0;
  logic   in_hold      = 1'b0;
  ticks_t hold_elapsed = '0;
  ticks_t since_repeat = '0;

  logic        pending_levels[$];   // tick beats waiting to be driven
  event_beat_t expected_events[$];  // predicted event beats, oldest first

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  logic idle_ticks  = 1'b1;         // per phase: gaps on the tick side
  logic idle_events = 1'b1;         // per phase: stalls on the event side

  function automatic ticks_t bump(ticks_t v);
    return (v == CFG_MAX) ? v : v + 1'b1;
  endfunction

  // One tick: counters advance first, then the level is judged.
  function automatic event_beat_t track_button(logic lvl);
    event_beat_t beat;
    beat.kind = EV_NONE;
    beat.held = ~lvl;
    since_press = bump(since_press);
    if (in_hold) begin
      if (!lvl) begin
        hold_elapsed = bump(hold_elapsed);
        since_repeat = bump(since_repeat);
        since_press  = '0;
        if (hold_elapsed > hold_initial_limit && since_repeat > hold_repeat_limit) begin
          beat.kind    = EV_REPEAT;
          since_repeat = '0;
        end
      end else begin
        // end of a followed hold restarts the debounce time
        in_hold     = 1'b0;
        since_press = '0;
      end
    end else if (last_level && !lvl && since_press > debounce_limit) begin
      beat.kind   = EV_PRESS;
      since_press = '0;
      // enable is only looked at here, so a hold in progress is unaffected by it
      if (hold_enable_bit) begin
        in_hold      = 1'b1;
        hold_elapsed = '0;
        since_repeat = '0;
      end
    end
    // bounced edges fall through without touching since_press
    last_level = lvl;
    return beat;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Tick driver: one level per beat from pending_levels; prediction is made
  // at the edge where the beat is taken, so expectations follow beat order.
  // ---------------------------------------------------------------------
  int tick_gap = 0;

  always @(posedge clk) begin : drive_ticks
    logic taken;
    taken = tick_ch.valid && tick_ch.ready;
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (taken) begin
        expected_events.push_back(track_button(tick_ch.button_level));
      end
      if (!tick_ch.valid || taken) begin
        if (tick_gap > 0) begin
          tick_gap--;
          tick_ch.valid <= 1'b0;
        end else if (pending_levels.size() != 0) begin
          tick_ch.valid        <= 1'b1;
          tick_ch.button_level <= pending_levels.pop_front();
          tick_gap = idle_ticks ? gap_len() : 0;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Event monitor: random backpressure, field-by-field compare
  // ---------------------------------------------------------------------
  int stall_gap = 0;

  always @(posedge clk) begin : watch_events
    event_beat_t want;
    if (rst) begin
      event_ch.ready <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: event beat with nothing expected: kind=%0d held=%0b",
                   $time, event_ch.event_kind, event_ch.held);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (event_ch.event_kind !== want.kind) begin
            $display("%0t: event_kind expected %0d actual %0d",
                     $time, want.kind, event_ch.event_kind);
            mismatches++;
          end
          if (event_ch.held !== want.held) begin
            $display("%0t: held expected %0b actual %0b", $time, want.held, event_ch.held);
            mismatches++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
        stall_gap = idle_events ? gap_len() : 0;
      end
    end
  end

  // Watchdog: counts cycles in which nothing moves at all.
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (event_ch.valid && event_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_run(logic lvl, int count);
    int n;
    n = (count < 1) ? 1 : count;
    repeat (n) pending_levels.push_back(lvl);
  endtask

  // Random length close to a threshold, so both sides of it are hit; above 60 it is any length up to 60.
  function automatic int near(int v);
    if (v > 60) return $urandom_range(1, 60);
    return $urandom_range((v > 2) ? v - 2 : 0, v + 3);
  endfunction

  // Wait for every beat to come back, then let the pipeline settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_levels.size() != 0 || tick_ch.valid || expected_events.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // All four registers, back to back; write enable drops after the last one.
  task automatic apply_settings(ticks_t d, ticks_t hi, ticks_t hr, logic en);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_HOLD_INITIAL;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_HOLD_REPEAT;
    cfg_data  <= hr;
    @(posedge clk);
    cfg_index <= REG_HOLD_ENABLE;
    cfg_data  <= CFG_W'(en);
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_limit     = d;
    hold_initial_limit = hi;
    hold_repeat_limit  = hr;
    hold_enable_bit    = en;
    @(negedge clk);
  endtask

  // Mostly press/hold/release cycles sized around the current thresholds,
  // with bounces on the edges; the rest is random chatter.
  // Called at a negedge, so the driver cannot pop while the queue is filled.
  task automatic add_random_items(int n);
    int goal;
    int pick;
    int hold_target;
    goal = pending_levels.size() + n;
    while (pending_levels.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // released stretch: often too short, often just around debounce
        if ($urandom_range(0, 3) == 0)
          push_run(1'b1, $urandom_range(1, 3));
        else
          push_run(1'b1, near(int'(debounce_limit) + 1));
        // bounce on the falling edge
        if ($urandom_range(0, 9) < 4) begin
          repeat ($urandom_range(1, 3)) begin
            push_run(1'b0, $urandom_range(1, 2));
            push_run(1'b1, $urandom_range(1, 2));
          end
        end
        hold_target = int'(hold_initial_limit)
                    + $urandom_range(0, 3) * (int'(hold_repeat_limit) + 1);
        push_run(1'b0, hold_enable_bit ? near(hold_target) : $urandom_range(1, 10));
        // bounce on release
        if ($urandom_range(0, 9) < 2) begin
          push_run(1'b1, 1);
          push_run(1'b0, $urandom_range(1, 2));
        end
      end else begin
        repeat ($urandom_range(1, 8)) pending_levels.push_back(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------
  initial begin : run_phases
    ticks_t d;
    ticks_t hi;
    ticks_t hr;
    logic   en;
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_DEBOUNCE;
    cfg_data             = '0;
    tick_ch.valid        = 1'b0;
    tick_ch.button_level = 1'b1;
    event_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Right after reset the debounce time runs from zero. A few ticks at the
    // reset settings: every edge bounces. Then a short debounce time: the
    // edge at exactly debounce_ticks bounces, the next one is a press.
    // Release after the hold restarts the time, so the quick edge after it
    // bounces.
    push_run(1'b1, 1);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    drain();
    apply_settings(ticks_t'(12), HOLD_INITIAL_RST, HOLD_REPEAT_RST, HOLD_ENABLE_RST);
    push_run(1'b1, 4);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 6);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    drain();

    // All thresholds zero: press, then a repeat on every held tick.
    apply_settings('0, '0, '0, 1'b1);
    push_run(1'b1, 1);
    push_run(1'b0, 4);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    drain();

    // Start a hold and leave it held across the settings change.
    apply_settings('0, ticks_t'(2), ticks_t'(1), 1'b1);
    push_run(1'b1, 1);
    push_run(1'b0, 6);
    drain();

    // Enable dropped mid hold: the running hold still repeats until release;
    // the next press is a single press.
    apply_settings('0, ticks_t'(2), ticks_t'(1), 1'b0);
    push_run(1'b0, 4);
    push_run(1'b1, 1);
    push_run(1'b0, 4);
    push_run(1'b1, 2);
    drain();

    // Largest thresholds: no press can clear debounce, nothing repeats.
    apply_settings(CFG_MAX, CFG_MAX, CFG_MAX, 1'b1);
    add_random_items(60);
    drain();

    // Random settings, some with one threshold at its top value.
    repeat (12) begin
      d  = ticks_t'($urandom_range(0, 12));
      hi = ticks_t'($urandom_range(0, 30));
      hr = ticks_t'($urandom_range(0, 8));
      en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0: hi = CFG_MAX;
        1: hr = CFG_MAX;
        2: d  = ticks_t'($urandom_range(40, 200));
        default: ;
      endcase
      apply_settings(d, hi, hr, en);
      idle_ticks  = ($urandom_range(0, 3) != 0);
      idle_events = ($urandom_range(0, 3) != 0);
      add_random_items(120);
      drain();
    end

    // Everything at zero with hold off: every clean edge is a single press.
    apply_settings('0, '0, '0, 1'b0);
    idle_ticks  = 1'b1;
    idle_events = 1'b1;
    add_random_items(60);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
